FILE: rtl/core/sp_pkg.sv
package sp_pkg;

  // default geometry
  localparam int ADDR_BITS_DEFAULT   = 48;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // block shift register
  localparam int              SHIFT_W           = 4;
  localparam logic [SHIFT_W-1:0] BLOCK_SHIFT_RESET = 4'd6;

  // stride confidence counter
  localparam int              CONF_W        = 2;
  localparam logic [CONF_W-1:0] CONF_RESTART  = 2'd1;
  localparam logic [CONF_W-1:0] CONF_PREFETCH = 2'd2;
  localparam logic [CONF_W-1:0] CONF_MAX      = 2'd3;

  // register port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_BLOCK_SHIFT = 1'b0;

  // per-access control that travels with the block index
  typedef struct packed {
    logic               conf_max;
    logic [SHIFT_W-1:0] shift;
  } ctl_t;

endpackage

FILE: rtl/core/sp_front.sv
module sp_front #(
  parameter int ADDR_BITS = sp_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [sp_pkg::SHIFT_W-1:0] block_shift_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ADDR_BITS-1:0]       access_addr_i,
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  output logic [ADDR_BITS-1:0]       cur_o,
  output logic [ADDR_BITS:0]         stride_o,
  output sp_pkg::ctl_t               ctl_o
);

  logic                       a_valid_q, a_valid_d;
  logic [ADDR_BITS-1:0]       a_cur_q, a_cur_d;
  logic [sp_pkg::SHIFT_W-1:0] a_shift_q, a_shift_d;

  logic                       seen_q;
  logic [ADDR_BITS-1:0]       prev_block_q;
  logic [ADDR_BITS:0]         prev_stride_q;
  logic [sp_pkg::CONF_W-1:0]  conf_q, conf_d;

  logic [ADDR_BITS:0] stride;
  logic               produce;
  logic               consume;
  logic               accept;

  always_comb begin
    stride = {1'b0, a_cur_q} - {1'b0, prev_block_q};
    if (stride == prev_stride_q) begin
      conf_d = (conf_q == sp_pkg::CONF_MAX) ? conf_q : conf_q + 2'd1;
    end else begin
      conf_d = sp_pkg::CONF_RESTART;
    end
    produce = seen_q && (conf_d >= sp_pkg::CONF_PREFETCH) && (stride != '0);
    consume = a_valid_q && (!produce || push_ready_i);
    accept  = in_valid_i && in_ready_o;
  end

  assign in_ready_o   = !a_valid_q || consume;
  assign push_valid_o = a_valid_q && produce;
  assign cur_o        = a_cur_q;
  assign stride_o     = stride;
  assign ctl_o        = '{conf_max: (conf_d == sp_pkg::CONF_MAX), shift: a_shift_q};

  always_comb begin
    a_valid_d = a_valid_q;
    a_cur_d   = a_cur_q;
    a_shift_d = a_shift_q;
    if (accept) begin
      a_valid_d = 1'b1;
      a_cur_d   = access_addr_i >> block_shift_i;
      a_shift_d = block_shift_i;
    end else if (consume) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_cur_q   <= a_cur_d;
    a_shift_q <= a_shift_d;
  end

  // stream history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q        <= 1'b0;
      prev_block_q  <= '0;
      prev_stride_q <= '0;
      conf_q        <= '0;
    end else if (consume) begin
      seen_q       <= 1'b1;
      prev_block_q <= a_cur_q;
      if (seen_q) begin
        prev_stride_q <= stride;
        conf_q        <= conf_d;
      end
    end
  end

endmodule

FILE: rtl/core/sp_queue.sv
module sp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/core/sp_back.sv
module sp_back #(
  parameter int ADDR_BITS = sp_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   pop_valid_i,
  output logic                   pop_ready_o,
  input  logic [ADDR_BITS-1:0]   cur_i,
  input  logic [ADDR_BITS:0]     stride_i,
  input  sp_pkg::ctl_t           ctl_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ADDR_BITS+1:0]   prefetch_addr_o,
  output logic                   last_of_run_o
);

  localparam int TGT_W = ADDR_BITS + 2;

  // magnitude stage
  logic                 x1_valid_q;
  logic [ADDR_BITS-1:0] x1_cur_q;
  logic [ADDR_BITS-1:0] x1_mag_q;
  logic                 x1_neg_q;
  sp_pkg::ctl_t         x1_ctl_q;

  // target stage
  logic                       x2_valid_q;
  logic [TGT_W-1:0]           x2_tgt0_q;
  logic [TGT_W-1:0]           x2_tgt1_q;
  logic                       x2_ok0_q;
  logic                       x2_ok1_q;
  logic [sp_pkg::SHIFT_W-1:0] x2_shift_q;

  // output stage
  logic             out_valid_q;
  logic [TGT_W-1:0] addr_q;
  logic [TGT_W-1:0] addr1_q;
  logic             second_q;

  logic             out_last_take;
  logic             out_free;
  logic             x2_adv;
  logic             x2_ready;
  logic             x1_adv;
  logic             x1_ready;
  logic             pop;
  logic [ADDR_BITS:0]   neg_stride;
  logic [ADDR_BITS-1:0] mag;
  logic [TGT_W-1:0]     sum1;
  logic [TGT_W-1:0]     sum2;
  logic [ADDR_BITS:0]   dif1;
  logic [TGT_W-1:0]     dif2;
  logic [TGT_W-1:0]     tgt0;
  logic [TGT_W-1:0]     tgt1;
  logic                 ok0;
  logic                 ok1;

  // handshake chain
  always_comb begin
    out_last_take = out_valid_q && out_ready_i && !second_q;
    out_free      = !out_valid_q || out_last_take;
    x2_adv        = x2_valid_q && (out_free || !x2_ok0_q);
    x2_ready      = !x2_valid_q || x2_adv;
    x1_adv        = x1_valid_q && x2_ready;
    x1_ready      = !x1_valid_q || x1_adv;
    pop           = pop_valid_i && x1_ready;
  end

  assign pop_ready_o = x1_ready;

  // stride magnitude
  always_comb begin
    neg_stride = ~stride_i + 1'b1;
    mag        = stride_i[ADDR_BITS] ? neg_stride[ADDR_BITS-1:0] : stride_i[ADDR_BITS-1:0];
  end

  // one and two strides ahead, either direction
  always_comb begin
    sum1 = {2'b00, x1_cur_q} + {2'b00, x1_mag_q};
    sum2 = {2'b00, x1_cur_q} + {1'b0, x1_mag_q, 1'b0};
    dif1 = {1'b0, x1_cur_q} - {1'b0, x1_mag_q};
    dif2 = {2'b00, x1_cur_q} - {1'b0, x1_mag_q, 1'b0};
    if (x1_neg_q) begin
      ok0  = !dif1[ADDR_BITS];
      ok1  = x1_ctl_q.conf_max && !dif1[ADDR_BITS] && !dif2[TGT_W-1];
      tgt0 = {2'b00, dif1[ADDR_BITS-1:0]};
      tgt1 = {2'b00, dif2[ADDR_BITS-1:0]};
    end else begin
      ok0  = 1'b1;
      ok1  = x1_ctl_q.conf_max;
      tgt0 = sum1;
      tgt1 = sum2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_valid_q  <= 1'b0;
      x2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      if (pop) begin
        x1_valid_q <= 1'b1;
      end else if (x1_adv) begin
        x1_valid_q <= 1'b0;
      end
      if (x1_adv) begin
        x2_valid_q <= 1'b1;
      end else if (x2_adv) begin
        x2_valid_q <= 1'b0;
      end
      if (x2_adv && x2_ok0_q) begin
        out_valid_q <= 1'b1;
        second_q    <= x2_ok1_q;
      end else if (out_valid_q && out_ready_i && second_q) begin
        second_q <= 1'b0;
      end else if (out_last_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      x1_cur_q <= cur_i;
      x1_mag_q <= mag;
      x1_neg_q <= stride_i[ADDR_BITS];
      x1_ctl_q <= ctl_i;
    end
    if (x1_adv) begin
      x2_tgt0_q  <= tgt0;
      x2_tgt1_q  <= tgt1;
      x2_ok0_q   <= ok0;
      x2_ok1_q   <= ok1;
      x2_shift_q <= x1_ctl_q.shift;
    end
    if (x2_adv && x2_ok0_q) begin
      addr_q  <= x2_tgt0_q << x2_shift_q;
      addr1_q <= x2_tgt1_q << x2_shift_q;
    end else if (out_valid_q && out_ready_i && second_q) begin
      addr_q <= addr1_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign prefetch_addr_o = addr_q;
  assign last_of_run_o   = !second_q;

  a_second_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> out_valid_q)
    else $error("second prefetch pending without a valid beat");

  a_far_needs_near: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x2_valid_q && x2_ok1_q) |-> x2_ok0_q)
    else $error("two-ahead target kept while one-ahead target dropped");

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i && second_q) |=> (out_valid_q && !second_q))
    else $error("second prefetch of a run lost after first beat");

endmodule

FILE: rtl/core/stride_prefetcher.sv
// single-stream stride prefetcher: every access beat on the input channel is reduced to a
// block index (address >> block_shift) and compared with the previous block; a repeated
// stride builds confidence (saturating at three), a new stride restarts it at one. once
// confidence reaches two with a nonzero stride, the block one stride ahead is issued as a
// block-aligned byte address, and at three the block two strides ahead follows; targets
// that would fall below block zero are dropped, and last_of_run_o marks the final beat of
// each access. one access is accepted per cycle while the queue has room; an access that
// yields two prefetches holds the output for two beats, so a stream at full confidence is
// paced by the output port, with the queue between front and back absorbing bursts. an
// accepted access passes capture, classification into the queue, magnitude, targets and
// the output register before its first prefetch beat. block_shift is written over the
// register port at byte address 0 and is only to be changed while no access is in flight
module stride_prefetcher #(
  parameter int ADDR_BITS   = sp_pkg::ADDR_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = sp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sp_pkg::PADDR_W-1:0] paddr,
  input  logic [sp_pkg::PDATA_W-1:0] pwdata,
  output logic [sp_pkg::PDATA_W-1:0] prdata,
  output logic                       pready,
  // access channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ADDR_BITS-1:0]       access_addr_i,
  // prefetch channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ADDR_BITS+1:0]       prefetch_addr_o,
  output logic                       last_of_run_o
);

  // queue entry: block index, signed stride, control
  localparam int CTL_W   = $bits(sp_pkg::ctl_t);
  localparam int ENTRY_W = ADDR_BITS + (ADDR_BITS + 1) + CTL_W;

  logic [sp_pkg::SHIFT_W-1:0] block_shift_q;
  logic                       sel_block_shift;
  logic                       cfg_write;

  logic                 push_valid;
  logic                 push_ready;
  logic [ADDR_BITS-1:0] front_cur;
  logic [ADDR_BITS:0]   front_stride;
  sp_pkg::ctl_t         front_ctl;
  logic [ENTRY_W-1:0]   push_data;

  logic                 pop_valid;
  logic                 pop_ready;
  logic [ENTRY_W-1:0]   pop_data;
  logic [ADDR_BITS-1:0] back_cur;
  logic [ADDR_BITS:0]   back_stride;
  sp_pkg::ctl_t         back_ctl;

  // register port: word index in the upper address bits, zero-wait
  assign sel_block_shift = (paddr[sp_pkg::PADDR_W-1:2] == sp_pkg::REG_BLOCK_SHIFT);
  assign cfg_write       = psel && penable && pwrite && pready && sel_block_shift;
  assign pready          = 1'b1;
  assign prdata          = sel_block_shift ?
                           {{(sp_pkg::PDATA_W - sp_pkg::SHIFT_W){1'b0}}, block_shift_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_shift_q <= sp_pkg::BLOCK_SHIFT_RESET;
    end else if (cfg_write) begin
      block_shift_q <= pwdata[sp_pkg::SHIFT_W-1:0];
    end
  end

  // front: capture, stride classification and stream history
  sp_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .block_shift_i (block_shift_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .access_addr_i (access_addr_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .cur_o         (front_cur),
    .stride_o      (front_stride),
    .ctl_o         (front_ctl)
  );

  // only accesses that reach prefetch confidence with a nonzero stride enter the queue
  assign push_data = {front_cur, front_stride, front_ctl};

  sp_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign back_cur    = pop_data[ENTRY_W-1 -: ADDR_BITS];
  assign back_stride = pop_data[CTL_W +: (ADDR_BITS + 1)];
  assign back_ctl    = sp_pkg::ctl_t'(pop_data[CTL_W-1:0]);

  // back: target arithmetic and beat sequencing
  sp_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .cur_i           (back_cur),
    .stride_i        (back_stride),
    .ctl_i           (back_ctl),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .prefetch_addr_o (prefetch_addr_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

FILE: verif/tb_stride_prefetcher.sv
module tb_stride_prefetcher;

  localparam int ADDR_BITS      = sp_pkg::ADDR_BITS_DEFAULT;
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int DRAIN_SLACK    = 8;     // pipe drain plus margin
  localparam int WATCHDOG_LIMIT = 3000;  // cycles without any beat
  localparam logic [sp_pkg::PADDR_W-1:0] SHIFT_ADDR = {sp_pkg::REG_BLOCK_SHIFT, 2'b00};

  typedef struct packed {
    logic [ADDR_BITS+1:0] addr;
    logic                 last;
  } prefetch_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         psel          = 1'b0;
  logic                         penable       = 1'b0;
  logic                         pwrite        = 1'b0;
  logic [sp_pkg::PADDR_W-1:0]   paddr         = '0;
  logic [sp_pkg::PDATA_W-1:0]   pwdata        = '0;
  logic [sp_pkg::PDATA_W-1:0]   prdata;
  logic                         pready;
  logic                         in_valid_i    = 1'b0;
  logic                         in_ready_o;
  logic [ADDR_BITS-1:0]         access_addr_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i   = 1'b0;
  logic [ADDR_BITS+1:0]         prefetch_addr_o;
  logic                         last_of_run_o;

  // predictor state, mirrors the block after reset
  logic                         seen_any_m   = 1'b0;
  logic [ADDR_BITS-1:0]         last_block_m = '0;
  logic [ADDR_BITS:0]           stride_m     = '0;
  logic [sp_pkg::CONF_W-1:0]    conf_m       = '0;
  logic [sp_pkg::SHIFT_W-1:0]   shift_m      = sp_pkg::BLOCK_SHIFT_RESET;

  prefetch_t   prefetch_q[$];
  prefetch_t   want;
  int          errors        = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_start    = 1'b0;
  int          hold_left     = 0;
  int          quiet_cycles  = 0;

  stride_prefetcher #(.ADDR_BITS(ADDR_BITS)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .access_addr_i  (access_addr_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .prefetch_addr_o(prefetch_addr_o),
    .last_of_run_o  (last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // works out the prefetch beats one access causes and queues them
  function automatic void predict_prefetches(input logic [ADDR_BITS-1:0] addr);
    logic [ADDR_BITS-1:0] blk;
    logic [ADDR_BITS:0]   step;
    logic [ADDR_BITS:0]   neg_step;
    logic [63:0]          cur;
    logic [63:0]          mag;
    logic [63:0]          scaled;
    logic [63:0]          tgt[2];
    bit                   ok[2];
    prefetch_t            hits[$];
    prefetch_t            hit;
    blk = addr >> shift_m;
    if (!seen_any_m) begin
      // first access only records its block
      seen_any_m   = 1'b1;
      last_block_m = blk;
      return;
    end
    step = {1'b0, blk} - {1'b0, last_block_m};
    if (step == stride_m) begin
      if (conf_m != sp_pkg::CONF_MAX) conf_m = conf_m + 1'b1;
    end else begin
      stride_m = step;
      conf_m   = sp_pkg::CONF_RESTART;
    end
    last_block_m = blk;
    if (conf_m < sp_pkg::CONF_PREFETCH || step == '0) return;
    cur = 64'(blk);
    if (step[ADDR_BITS]) begin
      // backwards stream, targets below block zero are dropped
      neg_step = ~step + 1'b1;
      mag      = 64'(neg_step);
      ok[0]    = (mag <= cur);
      ok[1]    = ok[0] && (mag <= cur - mag);
      tgt[0]   = cur - mag;
      tgt[1]   = cur - mag - mag;
    end else begin
      mag    = 64'(step);
      ok[0]  = 1'b1;
      ok[1]  = 1'b1;
      tgt[0] = cur + mag;
      tgt[1] = cur + mag + mag;
    end
    if (conf_m != sp_pkg::CONF_MAX) ok[1] = 1'b0;
    for (int k = 0; k < 2; k++) begin
      if (ok[k]) begin
        scaled   = tgt[k] << shift_m;
        hit.addr = scaled[ADDR_BITS+1:0];
        hit.last = 1'b0;
        hits     = {hits, hit};
      end
    end
    if (hits.size() > 0) hits[hits.size()-1].last = 1'b1;
    foreach (hits[i]) prefetch_q = {prefetch_q, hits[i]};
  endfunction

  function automatic logic [ADDR_BITS-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ADDR_BITS-1:0];
  endfunction

  // offers one access beat, valid stays high on return
  task automatic send_access(input logic [ADDR_BITS-1:0] addr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    access_addr_i <= addr;
    do @(posedge clk_i); while (!in_ready_o);
    predict_prefetches(addr);
  endtask

  // sender pauses until every expected prefetch has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (prefetch_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);
  endtask

  task automatic write_block_shift(input logic [sp_pkg::SHIFT_W-1:0] value);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SHIFT_ADDR;
    pwdata  <= sp_pkg::PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    shift_m = value;
    // read back through the same port
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[sp_pkg::SHIFT_W-1:0] !== value) begin
      $display("%0t: block_shift read back expected %0d actual %0d",
               $time, value, prdata[sp_pkg::SHIFT_W-1:0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // zero strides after the first access, including the first compare
  task automatic test_first_access();
    send_access(48'h0000_0000_1000);
    send_access(48'h0000_0000_1010);
    send_access(48'h0000_0000_1020);
  endtask

  // shift changed with state kept, then a stride building to full confidence
  task automatic test_stride_build_up();
    write_block_shift(4'd0);
    send_access(48'd200);
    send_access(48'd203);
    send_access(48'd206);
    send_access(48'd209);
    send_access(48'd212);
  endtask

  // backwards strides near block zero, first and second targets dropped
  task automatic test_negative_targets();
    send_access(48'd13);
    send_access(48'd10);
    send_access(48'd7);
    send_access(48'd4);
    send_access(48'd1);
    send_access(48'd0);
  endtask

  // top and bottom of the address range, largest shift, targets past 48 bits
  task automatic test_address_extremes();
    write_block_shift(4'd15);
    send_access(48'hFFFF_FFFF_FFFF);
    send_access(48'h0000_0000_0000);
    write_block_shift(4'd0);
    send_access(48'h0000_0000_0000);
    send_access(48'h7FFF_FFFF_FFFF);
    send_access(48'hFFFF_FFFF_FFFE);
  endtask

  // one stride run of random content at the current block shift
  task automatic send_stream(input int len, input int unsigned stride_kind);
    logic [63:0] base;
    logic [63:0] step;
    logic [63:0] lowmask;
    logic [63:0] addr;
    logic [63:0] top;
    lowmask = (64'd1 << shift_m) - 1;
    top     = (64'd1 << ADDR_BITS) >> shift_m;
    case ($urandom_range(0, 2))
      0:       base = 64'(rand_addr()) >> shift_m;
      1:       base = 64'($urandom_range(0, 40));
      default: base = top - 64'($urandom_range(1, 40));
    endcase
    case (stride_kind)
      0:       step = 64'($urandom_range(1, 4));
      1:       step = 64'($urandom_range(5, 1000));
      2:       step = 64'(rand_addr());
      default: step = '0;
    endcase
    if ($urandom_range(0, 1)) step = -step;
    for (int i = 0; i < len; i++) begin
      addr = ((base + step * i) << shift_m) | (64'({$urandom, $urandom}) & lowmask);
      send_access(addr[ADDR_BITS-1:0]);
    end
  endtask

  // mostly well-formed stride runs, the rest stray accesses
  task automatic test_random_streams(input int n_items,
                                     input logic [sp_pkg::SHIFT_W-1:0] shift);
    int sent;
    int len;
    int noise;
    write_block_shift(shift);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 80) begin
        len = $urandom_range(3, 10);
        send_stream(len, $urandom_range(0, 5) < 3 ? $urandom_range(0, 1)
                                                  : $urandom_range(0, 3));
        sent += len;
      end else begin
        noise = $urandom_range(1, 2);
        repeat (noise) send_access(rand_addr());
        sent += noise;
      end
    end
  endtask

  // a stream stops mid-way until all its prefetches are out, then carries on
  task automatic test_pause_until_drained();
    write_block_shift(4'd6);
    for (int i = 0; i < 10; i++) send_access(48'h0000_1234_0000 + 48'(i * 64));
    wait_drained();
    for (int i = 10; i < 20; i++) send_access(48'h0000_1234_0000 + 48'(i * 64));
  endtask

  // receiver holds off while the sender keeps offering a full-confidence stream
  task automatic test_receiver_hold_off();
    write_block_shift(4'd6);
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    for (int i = 0; i < 48; i++) send_access(48'h0000_8000_0000 + 48'(i * 128));
  endtask

  // prefetch sink, random stalls plus the requested long hold-off
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_start) begin
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // compares every prefetch beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (prefetch_q.size() == 0) begin
        $display("%0t: unexpected prefetch expected none actual addr %h last %b",
                 $time, prefetch_addr_o, last_of_run_o);
        errors++;
      end else begin
        want = prefetch_q.pop_front();
        if (prefetch_addr_o !== want.addr) begin
          $display("%0t: prefetch_addr expected %h actual %h",
                   $time, want.addr, prefetch_addr_o);
          errors++;
        end
        if (last_of_run_o !== want.last) begin
          $display("%0t: last_of_run expected %b actual %b",
                   $time, want.last, last_of_run_o);
          errors++;
        end
      end
    end
  end

  // ends a run that has stopped moving beats
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 28;
    recv_idle_pct = 87;
    test_first_access();
    test_stride_build_up();
    test_negative_targets();
    test_address_extremes();
    test_random_streams(240, 4'd12);
    test_random_streams(240, 4'd0);

    send_idle_pct = 87;
    recv_idle_pct = 28;
    test_pause_until_drained();
    test_random_streams(240, 4'd15);
    test_random_streams(240, sp_pkg::SHIFT_W'($urandom_range(0, 15)));

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_receiver_hold_off();
    test_random_streams(240, 4'd6);
    test_random_streams(220, sp_pkg::SHIFT_W'($urandom_range(1, 11)));

    wait_drained();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/sp_pkg.sv
rtl/core/sp_front.sv
rtl/core/sp_queue.sv
rtl/core/sp_back.sv
rtl/core/stride_prefetcher.sv
verif/tb_stride_prefetcher.sv
